### rtl/tks_pkg.sv
// Shared widths, limits and cell control type for the top-k score table.
`timescale 1ns / 1ps

package tks_pkg;

  localparam int unsigned SCORE_W = 17;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned RANK_W  = 4;

  localparam logic [SCORE_W-1:0] SCORE_MAX = 17'd99999;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 40;

  typedef struct packed {
    logic ins;
    logic rot;
  } cell_ctrl_t;

endpackage

### rtl/top_k_score_table.sv
// Top level of the top-k score table: slot chain, fill count, dump sequencer.
// An accepted item starts a dump; each result is registered from slot zero.
// A new item is accepted only in the idle state, once the last dump has ended;
// the dump rotates the whole slot chain once, ENTRIES steps, one per cycle.
// Output stalls pause the rotation while a result waits and out_tready stays low.
// Reset (rst_n low, synchronous) empties the table and idles the sequencer.
`timescale 1ns / 1ps

module top_k_score_table #(
  parameter int unsigned ENTRIES = 10
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [tks_pkg::IN_DATA_W-1:0]  in_tdata,  // new_score, player_tag
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [tks_pkg::OUT_DATA_W-1:0] out_tdata, // rank, entry_score, entry_tag
  output logic                           out_tlast
);

  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DUMP
  } state_t;

  state_t                      state_r;
  logic [CNT_W-1:0]            count_r;
  logic [CNT_W-1:0]            idx_r;
  logic                        out_valid_r;
  logic [tks_pkg::RANK_W-1:0]  rank_r;
  logic [tks_pkg::SCORE_W-1:0] oscore_r;
  logic [tks_pkg::TAG_W-1:0]   otag_r;
  logic                        olast_r;

  logic [tks_pkg::SCORE_W-1:0] raw_score;
  logic [tks_pkg::SCORE_W-1:0] sat_score;
  logic [tks_pkg::TAG_W-1:0]   in_tag;
  logic                        in_acc;
  logic                        emit;
  logic                        step;
  tks_pkg::cell_ctrl_t         ctrl;

  logic [tks_pkg::SCORE_W-1:0] cell_score [ENTRIES];
  logic [tks_pkg::TAG_W-1:0]   cell_tag   [ENTRIES];
  logic                        cell_lt    [ENTRIES];

  assign raw_score = in_tdata[tks_pkg::SCORE_W-1:0];
  assign in_tag    = in_tdata[tks_pkg::SCORE_W +: tks_pkg::TAG_W];
  assign sat_score = (raw_score > tks_pkg::SCORE_MAX) ? tks_pkg::SCORE_MAX : raw_score;

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign emit      = (idx_r < count_r);
  assign step      = (state_r == ST_DUMP) && (!emit || !out_valid_r || out_tready);
  assign ctrl.ins  = in_acc;
  assign ctrl.rot  = step;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic                        p_lt;
    logic [tks_pkg::SCORE_W-1:0] p_score;
    logic [tks_pkg::TAG_W-1:0]   p_tag;
    logic [tks_pkg::SCORE_W-1:0] n_score;
    logic [tks_pkg::TAG_W-1:0]   n_tag;

    if (i == 0) begin : g_head
      assign p_lt    = 1'b0;
      assign p_score = sat_score;
      assign p_tag   = in_tag;
    end else begin : g_body
      assign p_lt    = cell_lt[i-1];
      assign p_score = cell_score[i-1];
      assign p_tag   = cell_tag[i-1];
    end

    if (i == ENTRIES - 1) begin : g_tail
      assign n_score = cell_score[0];
      assign n_tag   = cell_tag[0];
    end else begin : g_mid
      assign n_score = cell_score[i+1];
      assign n_tag   = cell_tag[i+1];
    end

    tks_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .used       (count_r > CNT_W'(i)),
      .new_score  (sat_score),
      .new_tag    (in_tag),
      .prev_lt    (p_lt),
      .prev_score (p_score),
      .prev_tag   (p_tag),
      .next_score (n_score),
      .next_tag   (n_tag),
      .lt         (cell_lt[i]),
      .score      (cell_score[i]),
      .tag        (cell_tag[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_tready && !(step && emit)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (cell_lt[ENTRIES-1] && (count_r < CNT_W'(ENTRIES))) begin
              count_r <= count_r + 1'b1;
            end
            idx_r   <= '0;
            state_r <= ST_DUMP;
          end
        end
        ST_DUMP: begin
          if (step) begin
            if (emit) begin
              out_valid_r <= 1'b1;
              rank_r      <= tks_pkg::RANK_W'(idx_r + 1'b1);
              oscore_r    <= cell_score[0];
              otag_r      <= cell_tag[0];
              olast_r     <= ((idx_r + 1'b1) == count_r);
            end
            if (idx_r == CNT_W'(ENTRIES - 1)) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {3'b000, otag_r, oscore_r, rank_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("fill count above table size");

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (count_r != '0))
    else $error("table empty after a submission");

  a_dump_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DUMP) && (idx_r == '0))
    else $error("dump did not start after accepted item");

  a_last_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (step && emit && ((idx_r + 1'b1) == count_r)) |=> out_tvalid && out_tlast)
    else $error("final entry not marked");
`endif

endmodule

### rtl/tks_cell.sv
// One slot of the sorted score chain: sorted insert and rotate toward slot zero.
`timescale 1ns / 1ps

module tks_cell (
  input  logic                        clk,
  input  tks_pkg::cell_ctrl_t         ctrl,
  input  logic                        used,
  input  logic [tks_pkg::SCORE_W-1:0] new_score,
  input  logic [tks_pkg::TAG_W-1:0]   new_tag,
  input  logic                        prev_lt,
  input  logic [tks_pkg::SCORE_W-1:0] prev_score,
  input  logic [tks_pkg::TAG_W-1:0]   prev_tag,
  input  logic [tks_pkg::SCORE_W-1:0] next_score,
  input  logic [tks_pkg::TAG_W-1:0]   next_tag,
  output logic                        lt,
  output logic [tks_pkg::SCORE_W-1:0] score,
  output logic [tks_pkg::TAG_W-1:0]   tag
);

  logic [tks_pkg::SCORE_W-1:0] score_r;
  logic [tks_pkg::TAG_W-1:0]   tag_r;

  // new item belongs at or above this slot
  assign lt    = !used || (score_r < new_score);
  assign score = score_r;
  assign tag   = tag_r;

  always_ff @(posedge clk) begin
    if (ctrl.ins) begin
      if (prev_lt) begin
        score_r <= prev_score;
        tag_r   <= prev_tag;
      end else if (lt) begin
        score_r <= new_score;
        tag_r   <= new_tag;
      end
    end else if (ctrl.rot) begin
      score_r <= next_score;
      tag_r   <= next_tag;
    end
  end

endmodule

### verif/testbench.sv
// Self-checking testbench for the top-k score table: directed and random submissions.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IN_DATA_W  = tks_pkg::IN_DATA_W;
  localparam int unsigned OUT_DATA_W = tks_pkg::OUT_DATA_W;
  localparam int unsigned SCORE_W    = tks_pkg::SCORE_W;
  localparam int unsigned TAG_W      = tks_pkg::TAG_W;
  localparam int unsigned RANK_W     = tks_pkg::RANK_W;
  localparam logic [SCORE_W-1:0] SCORE_MAX = tks_pkg::SCORE_MAX;

  localparam int unsigned ENTRIES = 10;
  localparam int unsigned PAD_W = IN_DATA_W - SCORE_W - TAG_W;
  localparam int unsigned RANDOM_ITEMS = 280;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned IDLE_LIMIT = 3000;

  typedef struct {
    logic [RANK_W-1:0]  rank;
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } dump_entry_t;

  typedef struct {
    logic [SCORE_W-1:0] score;
    logic [TAG_W-1:0]   tag;
    bit                 pinned;
    logic [SCORE_W-1:0] top_score;
    logic [TAG_W-1:0]   top_tag;
  } submit_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // new_score, player_tag
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // rank, entry_score, entry_tag
  logic                  out_tlast;

  logic [SCORE_W-1:0] board_score [ENTRIES];
  logic [TAG_W-1:0]   board_tag [ENTRIES];
  int                 board_n = 0;
  dump_entry_t        table_dump_q [$];
  submit_row_t        opening_plan [18];
  int                 mismatches = 0;
  int                 items_in = 0;
  int                 burst_left = 0;
  int                 idle_cycles = 0;

  top_k_score_table #(.ENTRIES(ENTRIES)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // insert after all equal-or-higher scores, then queue the full table dump (rank one pinned if asked)
  function automatic void post_score(input logic [SCORE_W-1:0] raw,
                                     input logic [TAG_W-1:0] tag, input bit pinned,
                                     input logic [SCORE_W-1:0] top_score,
                                     input logic [TAG_W-1:0] top_tag);
    logic [SCORE_W-1:0] s;
    int pos;
    int i;
    dump_entry_t e;
    s = (raw > SCORE_MAX) ? SCORE_MAX : raw;
    pos = 0;
    while (pos < board_n && board_score[pos] >= s) pos++;
    if (pos < ENTRIES) begin
      i = (board_n < ENTRIES) ? board_n : ENTRIES - 1;
      while (i > pos) begin
        board_score[i] = board_score[i-1];
        board_tag[i] = board_tag[i-1];
        i--;
      end
      board_score[pos] = s;
      board_tag[pos] = tag;
      if (board_n < ENTRIES) board_n++;
    end
    for (i = 0; i < board_n; i++) begin
      e.rank = RANK_W'(i + 1);
      e.score = board_score[i];
      e.tag = board_tag[i];
      e.last = (i + 1 == board_n);
      if (pinned && i == 0) begin
        e.score = top_score;
        e.tag = top_tag;
      end
      table_dump_q.push_back(e);
    end
  endfunction

  // mostly scores near the table contents so ties, drops and mid inserts stay common
  function automatic logic [SCORE_W-1:0] pick_score();
    logic [SCORE_W-1:0] lowest;
    int r;
    lowest = (board_n > 0) ? board_score[board_n-1] : '0;
    r = $urandom_range(19, 0);
    if (r < 6) return lowest + SCORE_W'($urandom_range(40, 0));
    else if (r < 11) return board_score[$urandom_range(board_n - 1, 0)];
    else if (r < 15) return SCORE_W'($urandom_range(99999, lowest));
    else if (r < 17) return SCORE_W'($urandom_range(131071, 0));
    else if (r < 19) return SCORE_W'($urandom_range(lowest, 0));
    else return SCORE_W'($urandom_range(131071, 99999));
  endfunction

  task automatic offer(input logic [SCORE_W-1:0] sc, input logic [TAG_W-1:0] tg,
                       input bit pinned, input logic [SCORE_W-1:0] top_score,
                       input logic [TAG_W-1:0] top_tag);
    in_tdata <= {{PAD_W{1'b0}}, tg, sc};
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    post_score(sc, tg, pinned, top_score, top_tag);
    items_in++;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(8, 0);
    end else begin
      burst_left--;
    end
  endtask

  initial begin
    opening_plan = '{
      '{17'd500,    16'd1,      1'b1, 17'd500,   16'd1},
      '{17'd0,      16'd0,      1'b1, 17'd500,   16'd1},
      '{17'h1FFFF,  16'hFFFF,   1'b1, 17'd99999, 16'hFFFF},
      '{17'd99999,  16'd2,      1'b1, 17'd99999, 16'hFFFF},
      '{17'd100000, 16'd3,      1'b1, 17'd99999, 16'hFFFF},
      '{17'd500,    16'd4,      1'b0, 17'd0,     16'd0},
      '{17'd1,      16'd5,      1'b0, 17'd0,     16'd0},
      '{17'd250,    16'd6,      1'b0, 17'd0,     16'd0},
      '{17'd250,    16'd7,      1'b0, 17'd0,     16'd0},
      '{17'd750,    16'd8,      1'b0, 17'd0,     16'd0},
      '{17'd0,      16'd9,      1'b1, 17'd99999, 16'hFFFF},
      '{17'd1,      16'd10,     1'b0, 17'd0,     16'd0},
      '{17'd1,      16'd11,     1'b0, 17'd0,     16'd0},
      '{17'h1FFFF,  16'd12,     1'b1, 17'd99999, 16'hFFFF},
      '{17'h0AAAA,  16'hAAAA,   1'b0, 17'd0,     16'd0},
      '{17'h15555,  16'h5555,   1'b0, 17'd0,     16'd0},
      '{17'd99998,  16'h8000,   1'b0, 17'd0,     16'd0},
      '{17'd99999,  16'h7FFF,   1'b0, 17'd0,     16'd0}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (opening_plan[k])
      offer(opening_plan[k].score, opening_plan[k].tag, opening_plan[k].pinned,
            opening_plan[k].top_score, opening_plan[k].top_tag);
    repeat (RANDOM_ITEMS) offer(pick_score(), TAG_W'($urandom), 1'b0, '0, '0);
    in_tvalid <= 1'b0;
    while (table_dump_q.size() != 0) @(posedge clk);
    repeat (ENTRIES + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // receiver: stretches of different stall patterns, one long hold-off mid-run
  initial begin : result_sink
    bit held;
    int mode;
    held = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      mode = $urandom_range(3, 0);
      repeat ($urandom_range(120, 20)) begin
        if (!held && items_in >= 90) begin
          held = 1'b1;
          out_tready <= 1'b0;
          repeat (HOLD_CYCLES) @(posedge clk);
        end
        case (mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(1, 0);
          2: out_tready <= ($urandom_range(3, 0) == 0);
          default: out_tready <= ($urandom_range(5, 0) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : result_check
    dump_entry_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (table_dump_q.size() == 0) begin
        $error("unexpected result: rank %0d score %0d tag %0d", out_tdata[RANK_W-1:0],
               out_tdata[RANK_W +: SCORE_W], out_tdata[RANK_W+SCORE_W +: TAG_W]);
        mismatches++;
      end else begin
        want = table_dump_q.pop_front();
        if (out_tdata[RANK_W-1:0] !== want.rank) begin
          $error("rank: expected %0d, got %0d", want.rank, out_tdata[RANK_W-1:0]);
          mismatches++;
        end
        if (out_tdata[RANK_W +: SCORE_W] !== want.score) begin
          $error("entry_score: expected %0d, got %0d", want.score,
                 out_tdata[RANK_W +: SCORE_W]);
          mismatches++;
        end
        if (out_tdata[RANK_W+SCORE_W +: TAG_W] !== want.tag) begin
          $error("entry_tag: expected %0d, got %0d", want.tag,
                 out_tdata[RANK_W+SCORE_W +: TAG_W]);
          mismatches++;
        end
        if (out_tlast !== want.last) begin
          $error("last_entry: expected %0d, got %0d", want.last, out_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
rtl/tks_pkg.sv
rtl/tks_cell.sv
rtl/top_k_score_table.sv
verif/testbench.sv
